@@ hw/rtl/ulin_pkg.sv @@
// Shared types, widths and constants for the unicycle linearization core.
// No dependencies; imported by front, back, top level and testbench.
`timescale 1ns / 1ps
package ulin_pkg;

  localparam int CORDIC_STEPS_DEF = 16;
  localparam int CORDIC_STEPS_MAX = 24;

  localparam int B_W     = 18;
  localparam int RECIP_W = 23;
  localparam int GAIN_W  = 21;
  localparam int CFG_DW  = 23;
  localparam int HEAD_W  = 19;
  localparam int CW      = 34;   // CORDIC datapath and angle width (Q30)
  localparam int SC_W    = 18;   // sin/cos in Q16, range +-65536

  localparam logic signed [HEAD_W:0] PI_Q16      = 20'sd205887;
  localparam logic signed [HEAD_W:0] HALF_PI_Q16 = 20'sd102944;
  localparam logic signed [CW-1:0]   GAIN_Q30    = 34'sd652032874;

  localparam logic [31:0] ATAN_Q30 [CORDIC_STEPS_MAX] = '{
    32'd843314857, 32'd497837829, 32'd263043837, 32'd133525159, 32'd67021687,
    32'd33543516,  32'd16775851,  32'd8388437,   32'd4194283,   32'd2097149,
    32'd1048576,   32'd524288,    32'd262144,    32'd131072,    32'd65536,
    32'd32768,     32'd16384,     32'd8192,      32'd4096,      32'd2048,
    32'd1024,      32'd512,       32'd256,       32'd128
  };

  typedef enum logic [1:0] {
    REG_OFFSET_DISTANCE   = 2'd0,
    REG_OFFSET_RECIPROCAL = 2'd1,
    REG_GAIN_X            = 2'd2,
    REG_GAIN_Y            = 2'd3
  } ulin_reg_t;

  // Item after classification: heading folded into +-pi/2, angle in Q30.
  typedef struct packed {
    logic signed [31:0]   pos_x;
    logic signed [31:0]   pos_y;
    logic signed [31:0]   target_x;
    logic signed [31:0]   target_y;
    logic signed [31:0]   feed_vx;
    logic signed [31:0]   feed_vy;
    logic signed [CW-1:0] angle;
    logic                 fold;
  } ulin_item_t;

  typedef struct packed {
    logic signed [31:0] forward_speed;
    logic signed [31:0] turn_rate;
    logic               saturated;
  } ulin_result_t;

endpackage

@@ hw/rtl/ulin_fifo.sv @@
// Small register FIFO used between front and back and on the result side.
// Depends on nothing but its parameters.
`timescale 1ns / 1ps
module ulin_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_r, rd_r;
  logic [NW-1:0]    cnt_r;
  logic             do_push, do_pop;

  assign full    = (cnt_r == NW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) begin
        wr_r <= (wr_r == LAST) ? '0 : wr_r + 1'b1;
      end
      if (do_pop) begin
        rd_r <= (rd_r == LAST) ? '0 : rd_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end
endmodule

@@ hw/rtl/ulin_front.sv @@
// Front end: accepts items, folds the heading into +-pi/2 and scales it to Q30.
// Depends on ulin_pkg.
`timescale 1ns / 1ps
module ulin_front (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_push,
  output logic                      in_full,
  input  logic signed [31:0]        in_pos_x,
  input  logic signed [31:0]        in_pos_y,
  input  logic signed [18:0]        in_heading,
  input  logic signed [31:0]        in_target_x,
  input  logic signed [31:0]        in_target_y,
  input  logic signed [31:0]        in_feed_vx,
  input  logic signed [31:0]        in_feed_vy,
  input  logic                      dst_full,
  output logic                      dst_push,
  output ulin_pkg::ulin_item_t      dst_item
);
  import ulin_pkg::*;

  logic             valid_r;
  ulin_item_t       item_r, item_nxt;
  logic             take;
  logic signed [HEAD_W:0] h, hf;
  logic             fold;

  assign in_full  = valid_r && dst_full;
  assign take     = in_push && !in_full;
  assign dst_push = valid_r;
  assign dst_item = item_r;

  always_comb begin
    h    = (HEAD_W + 1)'(in_heading);
    hf   = h;
    fold = 1'b0;
    if (h > HALF_PI_Q16) begin
      hf   = h - PI_Q16;
      fold = 1'b1;
    end else if (h < -HALF_PI_Q16) begin
      hf   = h + PI_Q16;
      fold = 1'b1;
    end
    item_nxt.pos_x    = in_pos_x;
    item_nxt.pos_y    = in_pos_y;
    item_nxt.target_x = in_target_x;
    item_nxt.target_y = in_target_y;
    item_nxt.feed_vx  = in_feed_vx;
    item_nxt.feed_vy  = in_feed_vy;
    item_nxt.angle    = CW'(hf) <<< 14;
    item_nxt.fold     = fold;
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item_r <= item_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (take) begin
      valid_r <= 1'b1;
    end else if (!dst_full) begin
      valid_r <= 1'b0;
    end
  end
endmodule

@@ hw/rtl/ulin_back.sv @@
// Back end: pipelined CORDIC for sin/cos, then the control law and saturation.
// Depends on ulin_pkg. The whole pipeline advances while the result FIFO has room.
`timescale 1ns / 1ps
module ulin_back #(
  parameter int STEPS = ulin_pkg::CORDIC_STEPS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       src_valid,
  input  ulin_pkg::ulin_item_t       src_item,
  output logic                       src_pop,
  input  logic                       dst_full,
  output logic                       dst_push,
  output ulin_pkg::ulin_result_t     dst_result,
  input  logic [ulin_pkg::B_W-1:0]     offset_distance,
  input  logic [ulin_pkg::RECIP_W-1:0] offset_reciprocal,
  input  logic [ulin_pkg::GAIN_W-1:0]  gain_x,
  input  logic [ulin_pkg::GAIN_W-1:0]  gain_y
);
  import ulin_pkg::*;

  localparam int NPOST = 8;

  function automatic logic signed [SC_W-1:0] round_q16(
    input logic signed [CW-1:0] v, input logic neg);
    logic signed [CW-1:0]   r;
    logic signed [SC_W-1:0] c;
    r = (v + CW'(8192)) >>> 14;
    if (r > CW'(65536))       c = 18'sd65536;
    else if (r < -CW'(65536)) c = -18'sd65536;
    else                      c = SC_W'(r);
    return neg ? -c : c;
  endfunction

  function automatic logic [32:0] sat32(input logic signed [48:0] v);
    if (v > 49'sd2147483647)       return {1'b1, 32'h7FFF_FFFF};
    else if (v < -49'sd2147483648) return {1'b1, 32'h8000_0000};
    else                           return {1'b0, v[31:0]};
  endfunction

  logic adv;
  assign adv     = !dst_full;
  assign src_pop = adv && src_valid;

  // CORDIC rotation stages
  logic signed [CW-1:0] cx_r [STEPS+1];
  logic signed [CW-1:0] cy_r [STEPS+1];
  logic signed [CW-1:0] cz_r [STEPS+1];
  ulin_item_t           ci_r [STEPS+1];
  logic                 cv_r [STEPS+1];

  always_ff @(posedge clk) begin
    if (adv) begin
      cx_r[0] <= GAIN_Q30;
      cy_r[0] <= '0;
      cz_r[0] <= src_item.angle;
      ci_r[0] <= src_item;
    end
  end

  for (genvar i = 0; i < STEPS; i++) begin : g_rot
    localparam logic signed [CW-1:0] ANG = $signed({2'b00, ATAN_Q30[i]});
    always_ff @(posedge clk) begin
      if (adv) begin
        ci_r[i+1] <= ci_r[i];
        if (cz_r[i] >= 0) begin
          cx_r[i+1] <= cx_r[i] - (cy_r[i] >>> i);
          cy_r[i+1] <= cy_r[i] + (cx_r[i] >>> i);
          cz_r[i+1] <= cz_r[i] - ANG;
        end else begin
          cx_r[i+1] <= cx_r[i] + (cy_r[i] >>> i);
          cy_r[i+1] <= cy_r[i] - (cx_r[i] >>> i);
          cz_r[i+1] <= cz_r[i] + ANG;
        end
      end
    end
  end

  // Control law stages
  ulin_item_t             ia_r, ib_r;
  logic signed [SC_W-1:0] ca_r, sa_r, cb_r, sb_r, cc_r, sc_r, cd_r, sd_r, ce_r, se_r;
  logic signed [33:0]     lx_r, ly_r;
  logic signed [31:0]     fxc_r, fyc_r, fxd_r, fyd_r;
  logic signed [34:0]     dx_r, dy_r;
  logic signed [56:0]     pkx_r, pky_r;
  logic signed [40:0]     u1_r, u2_r;
  logic signed [58:0]     m1c_r, m2s_r, m2c_r, m1s_r;
  logic signed [43:0]     v_r, vh_r;
  logic signed [40:0]     t_r;
  logic signed [48:0]     w_r;
  logic                   pv_r [NPOST];

  logic signed [36:0] pbc, pbs;
  logic signed [59:0] sum_v, dif_t, tsh;
  logic signed [40:0] t_nxt;
  logic signed [64:0] pw;
  logic [32:0]        fs_s, tr_s;

  always_comb begin
    pbc   = $signed({1'b0, offset_distance}) * ca_r;
    pbs   = $signed({1'b0, offset_distance}) * sa_r;
    sum_v = 60'(m1c_r) + 60'(m2s_r);
    dif_t = 60'(m2c_r) - 60'(m1s_r);
    tsh   = dif_t >>> 16;
    if (tsh > (60'sd1 <<< 39))       t_nxt = 41'sd1 <<< 39;
    else if (tsh < -(60'sd1 <<< 39)) t_nxt = -(41'sd1 <<< 39);
    else                             t_nxt = 41'(tsh);
    pw    = t_r * $signed({1'b0, offset_reciprocal});
    fs_s  = sat32(49'(vh_r));
    tr_s  = sat32(w_r);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      // A: round sin/cos
      ca_r  <= round_q16(cx_r[STEPS], ci_r[STEPS].fold);
      sa_r  <= round_q16(cy_r[STEPS], ci_r[STEPS].fold);
      ia_r  <= ci_r[STEPS];
      // B: look-ahead point
      lx_r  <= 34'(ia_r.pos_x) + 34'(pbc >>> 16);
      ly_r  <= 34'(ia_r.pos_y) + 34'(pbs >>> 16);
      ib_r  <= ia_r;
      cb_r  <= ca_r;
      sb_r  <= sa_r;
      // C: tracking error
      dx_r  <= 35'(ib_r.target_x) - 35'(lx_r);
      dy_r  <= 35'(ib_r.target_y) - 35'(ly_r);
      fxc_r <= ib_r.feed_vx;
      fyc_r <= ib_r.feed_vy;
      cc_r  <= cb_r;
      sc_r  <= sb_r;
      // D: gain
      pkx_r <= $signed({1'b0, gain_x}) * dx_r;
      pky_r <= $signed({1'b0, gain_y}) * dy_r;
      fxd_r <= fxc_r;
      fyd_r <= fyc_r;
      cd_r  <= cc_r;
      sd_r  <= sc_r;
      // E: feedforward
      u1_r  <= 41'(fxd_r) + 41'(pkx_r >>> 16);
      u2_r  <= 41'(fyd_r) + 41'(pky_r >>> 16);
      ce_r  <= cd_r;
      se_r  <= sd_r;
      // F: rotation products
      m1c_r <= u1_r * ce_r;
      m2s_r <= u2_r * se_r;
      m2c_r <= u2_r * ce_r;
      m1s_r <= u1_r * se_r;
      // G: combine
      v_r   <= 44'(sum_v >>> 16);
      t_r   <= t_nxt;
      // H: scale by 1/b
      w_r   <= 49'(pw >>> 16);
      vh_r  <= v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= STEPS; k++) cv_r[k] <= 1'b0;
      for (int k = 0; k < NPOST; k++) pv_r[k] <= 1'b0;
    end else if (adv) begin
      cv_r[0] <= src_valid;
      for (int k = 0; k < STEPS; k++) cv_r[k+1] <= cv_r[k];
      pv_r[0] <= cv_r[STEPS];
      for (int k = 0; k < NPOST - 1; k++) pv_r[k+1] <= pv_r[k];
    end
  end

  assign dst_push                 = adv && pv_r[NPOST-1];
  assign dst_result.forward_speed = $signed(fs_s[31:0]);
  assign dst_result.turn_rate     = $signed(tr_s[31:0]);
  assign dst_result.saturated     = fs_s[32] | tr_s[32];
endmodule

@@ hw/rtl/unicycle_io_linearization_core.sv @@
// Unicycle input-output feedback linearization: top level, config registers, queues.
// Depends on ulin_pkg, ulin_front, ulin_fifo, ulin_back.
//
// Takes one pose/target item per cycle and returns one speed/turn command per item,
// in order. Throughput is one item per clock while out_pop keeps up. Each item
// passes in turn through the front register, the mid queue, the CORDIC load
// stage, one CORDIC stage per iteration, eight control-law stages and the result
// queue. The back pipeline freezes as a whole when the result queue is full; the
// front register and the two-entry queue between front and back let the front
// keep taking up to three items while the back is frozen. Sin/cos come from a
// CORDIC of CORDIC_STEPS iterations (up to 24); division by the look-ahead
// distance is a multiply by cfg register offset_reciprocal. Both outputs saturate
// to 32 bits and out_saturated flags the clip. The user must write config through
// cfg_we/cfg_index/cfg_data only while no item is in flight; nothing enforces it.
`timescale 1ns / 1ps
module unicycle_io_linearization_core #(
  parameter int CORDIC_STEPS = ulin_pkg::CORDIC_STEPS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [1:0]                    cfg_index,
  input  logic [ulin_pkg::CFG_DW-1:0]   cfg_data,
  input  logic                          in_push,
  output logic                          in_full,
  input  logic signed [31:0]            in_pos_x,
  input  logic signed [31:0]            in_pos_y,
  input  logic signed [18:0]            in_heading,
  input  logic signed [31:0]            in_target_x,
  input  logic signed [31:0]            in_target_y,
  input  logic signed [31:0]            in_feed_vx,
  input  logic signed [31:0]            in_feed_vy,
  output logic                          out_empty,
  input  logic                          out_pop,
  output logic signed [31:0]            out_forward_speed,
  output logic signed [31:0]            out_turn_rate,
  output logic                          out_saturated
);
  import ulin_pkg::*;

  logic [B_W-1:0]     offset_distance_r;
  logic [RECIP_W-1:0] offset_reciprocal_r;
  logic [GAIN_W-1:0]  gain_x_r, gain_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_distance_r   <= B_W'(13107);
      offset_reciprocal_r <= RECIP_W'(327680);
      gain_x_r            <= GAIN_W'(137626);
      gain_y_r            <= GAIN_W'(137626);
    end else if (cfg_we) begin
      case (ulin_reg_t'(cfg_index))
        REG_OFFSET_DISTANCE:   offset_distance_r   <= cfg_data[B_W-1:0];
        REG_OFFSET_RECIPROCAL: offset_reciprocal_r <= cfg_data[RECIP_W-1:0];
        REG_GAIN_X:            gain_x_r            <= cfg_data[GAIN_W-1:0];
        REG_GAIN_Y:            gain_y_r            <= cfg_data[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // front -> mid queue
  logic         f_push, mid_full, mid_empty, mid_pop;
  ulin_item_t   f_item, mid_item;
  // back -> result queue
  logic         r_push, r_full;
  ulin_result_t r_data, out_data;

  ulin_front u_front (
    .clk, .rst_n, .in_push, .in_full,
    .in_pos_x, .in_pos_y, .in_heading, .in_target_x, .in_target_y,
    .in_feed_vx, .in_feed_vy,
    .dst_full (mid_full), .dst_push (f_push), .dst_item (f_item)
  );

  ulin_fifo #(.WIDTH($bits(ulin_item_t)), .DEPTH(2)) u_mid (
    .clk, .rst_n,
    .push (f_push), .wdata (f_item), .full (mid_full),
    .pop (mid_pop), .rdata (mid_item), .empty (mid_empty)
  );

  ulin_back #(.STEPS(CORDIC_STEPS)) u_back (
    .clk, .rst_n,
    .src_valid (!mid_empty), .src_item (mid_item), .src_pop (mid_pop),
    .dst_full (r_full), .dst_push (r_push), .dst_result (r_data),
    .offset_distance (offset_distance_r), .offset_reciprocal (offset_reciprocal_r),
    .gain_x (gain_x_r), .gain_y (gain_y_r)
  );

  ulin_fifo #(.WIDTH($bits(ulin_result_t)), .DEPTH(2)) u_res (
    .clk, .rst_n,
    .push (r_push), .wdata (r_data), .full (r_full),
    .pop (out_pop), .rdata (out_data), .empty (out_empty)
  );

  assign out_forward_speed = out_data.forward_speed;
  assign out_turn_rate     = out_data.turn_rate;
  assign out_saturated     = out_data.saturated;
endmodule

@@ hw/rtl/ulin_checker.sv @@
// Port-level checks for the linearization core, bound to the top level.
// Depends on unicycle_io_linearization_core ports only.
`timescale 1ns / 1ps
module ulin_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_full,
  input logic               out_empty,
  input logic               out_pop,
  input logic signed [31:0] out_forward_speed,
  input logic signed [31:0] out_turn_rate,
  input logic               out_saturated
);
  localparam logic signed [31:0] MAXV = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] MINV = 32'sh8000_0000;

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("results visible right after reset");

  a_reset_ready: assert property (@(posedge clk) !rst_n |=> !in_full)
    else $error("input blocked right after reset");

  a_sat_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_saturated) |->
      (out_forward_speed == MAXV || out_forward_speed == MINV ||
       out_turn_rate == MAXV || out_turn_rate == MINV))
    else $error("saturated flag without a clipped output");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=>
      (!out_empty && $stable(out_forward_speed) && $stable(out_turn_rate) &&
       $stable(out_saturated)))
    else $error("waiting result changed");
endmodule

bind unicycle_io_linearization_core ulin_checker u_ulin_checker (
  .clk (clk), .rst_n (rst_n), .in_full (in_full), .out_empty (out_empty),
  .out_pop (out_pop), .out_forward_speed (out_forward_speed),
  .out_turn_rate (out_turn_rate), .out_saturated (out_saturated)
);

@@ tb/tb_unicycle_io_linearization_core.sv @@
// Self-checking testbench for unicycle_io_linearization_core.
// Depends on ulin_pkg and the core RTL; a built-in predictor models each command,
// and the run covers random traffic, register settings and back-pressure.
`timescale 1ns / 1ps
module tb_unicycle_io_linearization_core;
  import ulin_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;  // cycles with no item moving either way
  localparam int SETTLE_CYCLES  = 40;     // more than the pipeline latency

  typedef struct {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [18:0] heading;
    logic signed [31:0] target_x;
    logic signed [31:0] target_y;
    logic signed [31:0] feed_vx;
    logic signed [31:0] feed_vy;
  } pose_item_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [1:0] cfg_index;
  logic [CFG_DW-1:0] cfg_data;
  logic in_push;
  logic in_full;
  logic signed [31:0] in_pos_x, in_pos_y, in_target_x, in_target_y;
  logic signed [31:0] in_feed_vx, in_feed_vy;
  logic signed [18:0] in_heading;
  logic out_empty;
  logic out_pop;
  logic signed [31:0] out_forward_speed;
  logic signed [31:0] out_turn_rate;
  logic out_saturated;

  unicycle_io_linearization_core dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_push(in_push), .in_full(in_full),
    .in_pos_x(in_pos_x), .in_pos_y(in_pos_y), .in_heading(in_heading),
    .in_target_x(in_target_x), .in_target_y(in_target_y),
    .in_feed_vx(in_feed_vx), .in_feed_vy(in_feed_vy),
    .out_empty(out_empty), .out_pop(out_pop),
    .out_forward_speed(out_forward_speed), .out_turn_rate(out_turn_rate),
    .out_saturated(out_saturated)
  );

  // Shadow copy of the config registers
  longint offset_dist_q16;
  longint offset_recip_q16;
  longint gain_x_q16;
  longint gain_y_q16;

  ulin_result_t command_q[$];   // expected commands, oldest first
  int errors;
  int items_sent;
  int commands_seen;
  int sat_seen;
  int idle_cycles;

  // Receiver control: stall percentage and a long hold-off counter
  int pop_stall_pct;
  int hold_off_cycles;
  // Sender control: burst gaps on or off
  bit use_gaps;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor: CORDIC sin/cos, look-ahead point, P + feedforward, rotation.
  // ---------------------------------------------------------------------------
  function automatic longint clip(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic ulin_result_t predict_command(pose_item_t it);
    ulin_result_t r;
    longint hd, z, cx, cy, dx, dy, s, c;
    longint lx, ly, u1, u2, v, t, w, vs, ws;
    bit fold;
    hd = longint'(it.heading);
    fold = 1'b0;
    // fold into +-pi/2; the fold flips both sin and cos
    if (hd > longint'(HALF_PI_Q16)) begin
      hd = hd - longint'(PI_Q16);
      fold = 1'b1;
    end else if (hd < -longint'(HALF_PI_Q16)) begin
      hd = hd + longint'(PI_Q16);
      fold = 1'b1;
    end
    z  = hd * 16384;
    cx = longint'(GAIN_Q30);
    cy = 0;
    for (int i = 0; i < CORDIC_STEPS_DEF; i++) begin
      dx = cy >>> i;
      dy = cx >>> i;
      if (z >= 0) begin
        cx = cx - dx;
        cy = cy + dy;
        z  = z - longint'(ATAN_Q30[i]);
      end else begin
        cx = cx + dx;
        cy = cy - dy;
        z  = z + longint'(ATAN_Q30[i]);
      end
    end
    c = clip((cx + 8192) >>> 14, -65536, 65536);
    s = clip((cy + 8192) >>> 14, -65536, 65536);
    if (fold) begin
      c = -c;
      s = -s;
    end
    lx = longint'(it.pos_x) + ((offset_dist_q16 * c) >>> 16);
    ly = longint'(it.pos_y) + ((offset_dist_q16 * s) >>> 16);
    u1 = longint'(it.feed_vx) + ((gain_x_q16 * (longint'(it.target_x) - lx)) >>> 16);
    u2 = longint'(it.feed_vy) + ((gain_y_q16 * (longint'(it.target_y) - ly)) >>> 16);
    v  = (u1 * c + u2 * s) >>> 16;
    t  = clip((u2 * c - u1 * s) >>> 16, -(longint'(1) << 39), longint'(1) << 39);
    w  = (t * offset_recip_q16) >>> 16;
    vs = clip(v, -64'sd2147483648, 64'sd2147483647);
    ws = clip(w, -64'sd2147483648, 64'sd2147483647);
    r.forward_speed = vs[31:0];
    r.turn_rate     = ws[31:0];
    r.saturated     = (vs != v) || (ws != w);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Result checker: compares every popped item with the oldest expectation.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    ulin_result_t exp_cmd;
    if (rst_n && out_pop && !out_empty) begin
      commands_seen++;
      if (command_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected command fwd=%0d turn=%0d sat=%0b", $time,
                 out_forward_speed, out_turn_rate, out_saturated);
      end else begin
        exp_cmd = command_q.pop_front();
        if (exp_cmd.saturated) sat_seen++;
        if (out_forward_speed !== exp_cmd.forward_speed) begin
          errors++;
          $display("%0t: forward_speed expected %0d actual %0d", $time,
                   exp_cmd.forward_speed, out_forward_speed);
        end
        if (out_turn_rate !== exp_cmd.turn_rate) begin
          errors++;
          $display("%0t: turn_rate expected %0d actual %0d", $time,
                   exp_cmd.turn_rate, out_turn_rate);
        end
        if (out_saturated !== exp_cmd.saturated) begin
          errors++;
          $display("%0t: saturated expected %0b actual %0b", $time,
                   exp_cmd.saturated, out_saturated);
        end
      end
    end
  end

  // Receiver: random stalls, plus a long hold-off when asked for
  always @(posedge clk) begin
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else if (hold_off_cycles > 0) begin
      hold_off_cycles <= hold_off_cycles - 1;
      out_pop <= 1'b0;
    end else begin
      out_pop <= ($urandom_range(99) >= pop_stall_pct);
    end
  end

  // Watchdog: ends the run if nothing moves for too long
  always @(posedge clk) begin
    if ((in_push && !in_full) || (out_pop && !out_empty) || !rst_n) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no progress for %0d cycles", WATCHDOG_LIMIT);
      $display("unicycle_io_linearization_core verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers. All are entered and left at a rising edge.
  // ---------------------------------------------------------------------------
  // Drive one item, hold it until the core takes it, then log the expectation.
  task automatic send_item(pose_item_t it);
    in_push     <= 1'b1;
    in_pos_x    <= it.pos_x;
    in_pos_y    <= it.pos_y;
    in_heading  <= it.heading;
    in_target_x <= it.target_x;
    in_target_y <= it.target_y;
    in_feed_vx  <= it.feed_vx;
    in_feed_vy  <= it.feed_vy;
    // in_full is stable at the falling edge until the next rising edge
    do @(negedge clk); while (in_full);
    @(posedge clk);
    command_q.push_back(predict_command(it));
    items_sent++;
  endtask

  task automatic pause_sender(int cycles);
    in_push <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Stop sending and wait until every expected item came back, then let the
  // pipeline settle so a config write cannot land on an item in flight.
  task automatic drain_commands();
    in_push <= 1'b0;
    @(posedge clk);
    while (command_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(ulin_reg_t idx, int unsigned val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val[CFG_DW-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_OFFSET_DISTANCE:   offset_dist_q16  = longint'(val & 32'h3FFFF);
      REG_OFFSET_RECIPROCAL: offset_recip_q16 = longint'(val & 32'h7FFFFF);
      REG_GAIN_X:            gain_x_q16       = longint'(val & 32'h1FFFFF);
      REG_GAIN_Y:            gain_y_q16       = longint'(val & 32'h1FFFFF);
      default: ;
    endcase
  endtask

  task automatic write_all_regs(int unsigned b, int unsigned recip,
                                int unsigned kx, int unsigned ky);
    write_reg(REG_OFFSET_DISTANCE, b);
    write_reg(REG_OFFSET_RECIPROCAL, recip);
    write_reg(REG_GAIN_X, kx);
    write_reg(REG_GAIN_Y, ky);
  endtask

  function automatic int rand_span(int unsigned span);
    return int'($urandom_range(2 * span)) - int'(span);
  endfunction

  // Mostly plausible poses near the target; some fully random, some wild headings
  function automatic pose_item_t random_pose();
    pose_item_t it;
    int unsigned kind;
    kind = $urandom_range(99);
    if (kind < 25) begin
      it.pos_x    = $urandom;
      it.pos_y    = $urandom;
      it.target_x = $urandom;
      it.target_y = $urandom;
      it.feed_vx  = $urandom;
      it.feed_vy  = $urandom;
    end else begin
      it.pos_x    = rand_span(1 << 24);
      it.pos_y    = rand_span(1 << 24);
      it.target_x = it.pos_x + rand_span(1 << 18);
      it.target_y = it.pos_y + rand_span(1 << 18);
      it.feed_vx  = rand_span(1 << 18);
      it.feed_vy  = rand_span(1 << 18);
    end
    if ($urandom_range(9) == 0) it.heading = 19'($urandom);
    else it.heading = 19'(rand_span(205887));
    return it;
  endfunction

  // Stream n random items in bursts, with gaps when enabled
  task automatic stream_items(int n);
    int burst_left;
    burst_left = $urandom_range(20, 1);
    for (int k = 0; k < n; k++) begin
      send_item(random_pose());
      burst_left--;
      if (burst_left == 0) begin
        burst_left = $urandom_range(20, 1);
        if (use_gaps && k != n - 1) begin
          int gap;
          gap = $urandom_range(5);
          if (gap > 0) pause_sender(gap);
        end
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_directed();
    pose_item_t it;
    int signed headings[10];
    headings = '{0, 205887, -205887, 102944, -102944, 102945, -102945,
                 262143, -262144, 51472};
    // heading corners, including out of range and the pi/2 fold boundary
    foreach (headings[i]) begin
      it.pos_x = 32'sd65536; it.pos_y = -32'sd131072;
      it.target_x = 32'sd196608; it.target_y = 32'sd65536;
      it.feed_vx = 32'sd32768; it.feed_vy = -32'sd16384;
      it.heading = 19'(headings[i]);
      send_item(it);
    end
    // all zero, then field extremes driving both outputs into saturation
    it = '{default: 0};
    send_item(it);
    it.pos_x = 32'h7FFFFFFF; it.pos_y = 32'h80000000;
    it.target_x = 32'h80000000; it.target_y = 32'h7FFFFFFF;
    it.feed_vx = 32'h7FFFFFFF; it.feed_vy = 32'h7FFFFFFF; it.heading = 0;
    send_item(it);
    it.feed_vx = 32'h80000000; it.feed_vy = 32'h80000000; it.heading = 19'h3FFFF;
    send_item(it);
    it.pos_x = 32'h80000000; it.pos_y = 32'h7FFFFFFF;
    it.target_x = 32'h7FFFFFFF; it.target_y = 32'h80000000; it.heading = 19'h40000;
    send_item(it);
    it = '{default: -1};
    send_item(it);
    it.pos_x = 0; it.pos_y = 0; it.target_x = 0; it.target_y = 0;
    it.feed_vx = 32'h7FFFFFFF; it.feed_vy = 0; it.heading = 19'sd102944;
    send_item(it);
    drain_commands();
  endtask

  // Register sweep: reset values, range extremes, full-width values and a
  // reciprocal that does not match the distance.
  task automatic test_register_sweep();
    int unsigned settings[7][4];
    settings = '{
      '{13107, 327680, 137626, 137626},
      '{655, 6553600, 0, 0},
      '{131072, 32768, 1048576, 1048576},
      '{262143, 8388607, 2097151, 2097151},
      '{655, 32768, 1048576, 0},
      '{131072, 6553600, 0, 1048576},
      '{13107, 4000000, 65536, 300000}
    };
    use_gaps = 1'b1;
    pop_stall_pct = 30;
    foreach (settings[i]) begin
      write_all_regs(settings[i][0], settings[i][1], settings[i][2], settings[i][3]);
      stream_items(100);
      drain_commands();
    end
  endtask

  // Hold the receiver off long enough for the core to fill and stall its input,
  // then have the sender wait for everything to come back.
  task automatic test_backpressure();
    use_gaps = 1'b0;
    pop_stall_pct = 0;
    hold_off_cycles = 300;
    stream_items(150);
    drain_commands();
    pop_stall_pct = 80;
    stream_items(50);
    drain_commands();
  endtask

  task automatic test_random();
    for (int phase = 0; phase < 6; phase++) begin
      write_all_regs($urandom_range(131072, 655), $urandom_range(6553600, 32768),
                     $urandom_range(1048576), $urandom_range(1048576));
      use_gaps = (phase % 3) != 0;           // some phases at full rate
      pop_stall_pct = $urandom_range(60);
      stream_items(200);
      drain_commands();
    end
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = REG_OFFSET_DISTANCE;
    cfg_data = '0;
    in_push = 1'b0;
    in_pos_x = '0; in_pos_y = '0; in_heading = '0;
    in_target_x = '0; in_target_y = '0; in_feed_vx = '0; in_feed_vy = '0;
    errors = 0; items_sent = 0; commands_seen = 0; sat_seen = 0;
    idle_cycles = 0;
    pop_stall_pct = 20;
    hold_off_cycles = 0;
    use_gaps = 1'b1;
    // reset values of the config registers
    offset_dist_q16  = 13107;
    offset_recip_q16 = 327680;
    gain_x_q16       = 137626;
    gain_y_q16       = 137626;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_register_sweep();
    test_backpressure();
    test_random();

    if (command_q.size() != 0) begin
      errors++;
      $display("%0t: %0d expected commands never arrived", $time, command_q.size());
    end
    $display("sent %0d items, checked %0d commands (%0d saturated)", items_sent,
             commands_seen, sat_seen);
    $display("covered heading folds, field extremes, register sweeps, back-pressure");
    if (errors == 0) begin
      $display("unicycle_io_linearization_core verification clean");
    end else begin
      $display("unicycle_io_linearization_core verification failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/ulin_pkg.sv
hw/rtl/ulin_fifo.sv
hw/rtl/ulin_front.sv
hw/rtl/ulin_back.sv
hw/rtl/unicycle_io_linearization_core.sv
hw/rtl/ulin_checker.sv
tb/tb_unicycle_io_linearization_core.sv
